@@ rtl/core/whmc_pkg.sv @@
// whmc_pkg: shared types, widths and colour class codes for the window hue
// median classifier. Depends on nothing.
`timescale 1ns / 1ps

package whmc_pkg;

  localparam int HUE_W = 8;   // width of a hue sample
  localparam int CNT_W = 11;  // width of a bin count and the sample count
  localparam int CLS_W = 3;   // width of a colour class code

  typedef logic [HUE_W-1:0] hue_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [CLS_W-1:0] {
    CLS_NONE   = 3'd0,
    CLS_RED    = 3'd1,
    CLS_BLUE   = 3'd2,
    CLS_ORANGE = 3'd3,
    CLS_YELLOW = 3'd4,
    CLS_GREEN  = 3'd5
  } colour_class_t;

  typedef enum logic {
    ST_COUNT,
    ST_SCAN
  } state_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic inc_en;  // a sample transfer is counted this cycle
    hue_t hue;     // clamped hue of that sample
    logic shift;   // scan: take the neighbor's count, hand ours on
  } cell_ctl_t;

  // Later tests override earlier ones.
  function automatic colour_class_t classify_hue(input hue_t m);
    colour_class_t cls;
    cls = CLS_NONE;
    if (m < 8'd10 || m > 8'd170) cls = CLS_RED;
    if (m < 8'd140 && m > 8'd70) cls = CLS_BLUE;
    if (m < 8'd17 && m > 8'd5) cls = CLS_ORANGE;
    if (m < 8'd35 && m > 8'd18) cls = CLS_YELLOW;
    if (m < 8'd70 && m > 8'd40) cls = CLS_GREEN;
    return cls;
  endfunction

endpackage

@@ rtl/core/whmc_cell.sv @@
// whmc_cell: one histogram bin of the chain; counts matching samples and
// hands its count to the neighbor toward the head during a scan. Uses whmc_pkg.
`timescale 1ns / 1ps

module whmc_cell import whmc_pkg::*; #(
  parameter int BIN_INDEX = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  count_t    count_in,
  output count_t    count_out
);

  localparam hue_t BIN_HUE = hue_t'(BIN_INDEX);

  count_t count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (ctl.shift) begin
      count_nxt = count_in;
    end else if (ctl.inc_en && ctl.hue == BIN_HUE) begin
      count_nxt = count_r + count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count_out = count_r;

endmodule

@@ rtl/core/window_hue_median_classifier.sv @@
// window_hue_median_classifier: top level; a chain of histogram cells, the
// sample counter, the rank scan sequencer and the result register.
// Uses whmc_pkg and whmc_cell.
`timescale 1ns / 1ps

// Channel   Ports                                   Transfer
// input     start, busy, in_hue, in_last_sample     start high and busy low
// result    out_valid, out_median_hue,              out_valid high, one cycle
//           out_colour_class
//
// A sample is taken every cycle that start is high and busy is low. The sample that
// closes a window (last mark, or the WINDOW_SAMPLES-th sample) starts a scan,
// with busy high: the bin counts shift toward the head of the chain one cell
// a cycle and a running sum there finds the median rank. Zeros shift in behind,
// so the same scan clears the histogram. The result shows on the cycle after the
// scan ends, when busy is already low again. Reset clears all bins and the
// counter at once. The receiver cannot stall.

module window_hue_median_classifier import whmc_pkg::*; #(
  parameter int WINDOW_SAMPLES = 400,
  parameter int MEDIAN_RANK    = 200,
  parameter int HUE_BINS       = 180
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [HUE_W-1:0] in_hue,
  input  logic             in_last_sample,
  output logic             out_valid,
  output logic [HUE_W-1:0] out_median_hue,
  output logic [CLS_W-1:0] out_colour_class
);

  localparam int IDX_W = (HUE_BINS > 1) ? $clog2(HUE_BINS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HUE_BINS - 1);
  localparam hue_t TOP_HUE = hue_t'(HUE_BINS - 1);
  localparam count_t WIN_LIMIT = count_t'(WINDOW_SAMPLES);
  localparam count_t RANK_CFG = count_t'(MEDIAN_RANK);

  state_t            state_r, state_nxt;
  count_t            samples_r, samples_nxt;
  count_t            rank_r, rank_nxt;
  count_t            cum_r, cum_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              found_r, found_nxt;
  hue_t              bin_r, bin_nxt;
  logic              out_valid_r, out_valid_nxt;
  hue_t              median_r, median_nxt;
  logic [CLS_W-1:0]  class_r, class_nxt;

  logic      accept;
  logic      closes;
  hue_t      hue_clamped;
  count_t    count_plus;
  logic      hit;
  cell_ctl_t ctl;
  count_t    chain [HUE_BINS+1];

  // Histogram chain: cell 0 is the head read by the scan; the tail takes zeros.
  assign chain[HUE_BINS] = '0;

  for (genvar i = 0; i < HUE_BINS; i++) begin : g_cell
    whmc_cell #(
      .BIN_INDEX(i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .count_in (chain[i+1]),
      .count_out(chain[i])
    );
  end

  assign busy        = (state_r == ST_SCAN);
  assign accept      = start && !busy;
  // Fold out-of-range hues into the top bin.
  assign hue_clamped = (in_hue >= TOP_HUE) ? TOP_HUE : in_hue;
  assign count_plus  = samples_r + count_t'(1);
  assign closes      = in_last_sample || (count_plus >= WIN_LIMIT);

  assign ctl.inc_en = accept;
  assign ctl.hue    = hue_clamped;
  assign ctl.shift  = busy;

  assign cum_nxt = busy ? (cum_r + chain[0]) : '0;
  assign hit     = !found_r && (cum_nxt > rank_r);

  always_comb begin
    state_nxt     = state_r;
    samples_nxt   = samples_r;
    rank_nxt      = rank_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    bin_nxt       = bin_r;
    out_valid_nxt = 1'b0;
    median_nxt    = median_r;
    class_nxt     = class_r;
    case (state_r)
      ST_COUNT: begin
        if (accept) begin
          if (closes) begin
            // Saturate the rank to the last sample of a short window.
            rank_nxt    = (RANK_CFG >= count_plus) ? (count_plus - count_t'(1)) : RANK_CFG;
            samples_nxt = '0;
            idx_nxt     = '0;
            found_nxt   = 1'b0;
            state_nxt   = ST_SCAN;
          end else begin
            samples_nxt = count_plus;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          found_nxt = 1'b1;
          bin_nxt   = hue_t'(idx_r);
        end
        if (idx_r == LAST_IDX) begin
          // Drop back to counting and present the result.
          if (found_r) begin
            median_nxt = bin_r;
          end else if (hit) begin
            median_nxt = hue_t'(idx_r);
          end else begin
            median_nxt = TOP_HUE;
          end
          class_nxt     = classify_hue(median_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_COUNT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COUNT;
      samples_r   <= '0;
      cum_r       <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      samples_r   <= samples_nxt;
      cum_r       <= cum_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    rank_r   <= rank_nxt;
    bin_r    <= bin_nxt;
    median_r <= median_nxt;
    class_r  <= class_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_median_hue   = median_r;
  assign out_colour_class = class_r;

endmodule
